// File: rtl/core/wmg_pkg.sv
`timescale 1ns / 1ps
// shared constants for the windowed multitone generator
// no dependencies; used by wmg_sine and windowed_multitone_generator in rtl/core
package wmg_pkg;

    // default parameter values
    localparam int PHASE_BITS_DEF = 16;
    localparam int CHANNELS_DEF   = 3;

    // bits handled by one divider stage
    localparam int DIV_STEP = 4;

    // configuration register indexes
    localparam logic [2:0] REG_CH0      = 3'd0;
    localparam logic [2:0] REG_CH1      = 3'd1;
    localparam logic [2:0] REG_CH2      = 3'd2;
    localparam logic [2:0] REG_WINDOW   = 3'd3;
    localparam logic [2:0] REG_NPOINTS  = 3'd4;

    // waveform kinds
    localparam logic [1:0] WAVE_OFF    = 2'd0;
    localparam logic [1:0] WAVE_SINE   = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_SAW    = 2'd3;

    // window modes
    localparam logic [2:0] WIN_NONE     = 3'd0;
    localparam logic [2:0] WIN_BLACKMAN = 3'd1;
    localparam logic [2:0] WIN_HANN     = 3'd2;
    localparam logic [2:0] WIN_HAMMING  = 3'd3;
    localparam logic [2:0] WIN_BARTLETT = 3'd4;

    // sine polynomial coefficients, q16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [15:0] SIN_B = 16'd42047;
    localparam logic [12:0] SIN_C = 13'd4640;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // window coefficients, q16
    localparam logic signed [34:0] BK_A0   = 35'sd27525;
    localparam logic signed [15:0] BK_A2   = 16'sd5243;
    localparam logic signed [34:0] HM_A0   = 35'sd35389;
    localparam logic signed [15:0] HM_A1   = 16'sd30147;
    localparam logic signed [34:0] WIN_ONE = 35'sd65536;

    // reset value of the record length
    localparam logic [15:0] NPOINTS_RST = 16'd1024;

    // field and data widths
    localparam int CFG_W    = 50;
    localparam int IDX_W    = 3;
    localparam int WAVE_W   = 18;
    localparam int CHV_W    = 35;
    localparam int SUM_W    = 37;
    localparam int S16_W    = 29;
    localparam int WIN_W    = 35;
    localparam int OUT_W    = 20;
    localparam logic signed [39:0] OUT_MAX = 40'sd524287;
    localparam logic signed [39:0] OUT_MIN = -40'sd524288;

endpackage

// File: rtl/core/wmg_delay.sv
`timescale 1ns / 1ps
// fixed-depth delay line with shared stall enable
// depends on nothing
module wmg_delay #(
    parameter int W     = 18,
    parameter int DEPTH = 5
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// File: rtl/core/wmg_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, integer and fraction quotient bits
// depends on nothing; divisor held steady while items are in flight
module wmg_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 20,
    parameter int FRAC_W = 17,
    parameter int STEP   = 4
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [DEN_W-1:0]          i_den,
    output logic [NUM_W+FRAC_W-1:0]   o_quot,
    output logic [DEN_W-1:0]          o_rem
);

    localparam int T = NUM_W + FRAC_W;
    localparam int L = (T + STEP - 1) / STEP;

    logic [DEN_W-1:0] r_rem  [L];
    logic [T-1:0]     r_dvd  [L];
    logic [T-1:0]     r_quot [L];

    for (genvar s = 0; s < L; s++) begin : g_stage
        logic [DEN_W-1:0] w_rem_in;
        logic [T-1:0]     w_dvd_in;
        logic [T-1:0]     w_quot_in;
        logic [DEN_W-1:0] n_rem;
        logic [T-1:0]     n_dvd;
        logic [T-1:0]     n_quot;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_dvd_in  = {i_num, {FRAC_W{1'b0}}};
            assign w_quot_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_dvd_in  = r_dvd[s-1];
            assign w_quot_in = r_quot[s-1];
        end

        always_comb begin
            logic [DEN_W:0] t;
            n_rem  = w_rem_in;
            n_dvd  = w_dvd_in;
            n_quot = w_quot_in;
            t      = '0;
            for (int k = 0; k < STEP; k++) begin
                if (s * STEP + k < T) begin
                    t     = {n_rem, n_dvd[T-1]};
                    n_dvd = n_dvd << 1;
                    if (t >= {1'b0, i_den}) begin
                        t      = t - {1'b0, i_den};
                        n_quot = {n_quot[T-2:0], 1'b1};
                    end else begin
                        n_quot = {n_quot[T-2:0], 1'b0};
                    end
                    n_rem = t[DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_dvd[s]  <= n_dvd;
                r_quot[s] <= n_quot;
            end
        end
    end

    assign o_quot = r_quot[L-1];
    assign o_rem  = r_rem[L-1];

endmodule

// File: rtl/core/wmg_sine.sv
`timescale 1ns / 1ps
// five-stage polynomial sine of a turn fraction, q16 result
// depends on wmg_pkg for the coefficients
module wmg_sine #(
    parameter int PHASE_BITS = wmg_pkg::PHASE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [PHASE_BITS-1:0]  i_ang,
    output logic signed [17:0]     o_val
);

    localparam int XB = PHASE_BITS - 2;

    logic [16:0] r_x1, r_x2, r_x3, r_x4;
    logic [16:0] r_sq2, r_sq3;
    logic [15:0] r_t3;
    logic [16:0] r_t4;
    logic        r_neg1, r_neg2, r_neg3, r_neg4;
    logic signed [17:0] r_y;

    logic [XB+15:0] w_xt;
    logic [16:0]    w_x0;
    logic [33:0]    w_m1, w_m2, w_m3, w_m4;
    logic [16:0]    w_y;

    // fold the quadrant onto a quarter turn
    assign w_xt = {i_ang[XB-1:0], 16'd0};
    always_comb begin
        w_x0 = 17'(w_xt >> XB);
        if (i_ang[XB]) begin
            w_x0 = wmg_pkg::ONE_Q16 - w_x0;
        end
    end

    assign w_m1 = r_x1 * r_x1;
    assign w_m2 = wmg_pkg::SIN_C * r_sq2;
    assign w_m3 = r_t3 * r_sq3;
    assign w_m4 = r_t4 * r_x4;

    always_comb begin
        w_y = w_m4[32:16];
        if (w_y > wmg_pkg::ONE_Q16) begin
            w_y = wmg_pkg::ONE_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= w_x0;
            r_neg1 <= i_ang[PHASE_BITS-1];

            r_sq2  <= w_m1[32:16];
            r_x2   <= r_x1;
            r_neg2 <= r_neg1;

            r_t3   <= wmg_pkg::SIN_B - w_m2[31:16];
            r_sq3  <= r_sq2;
            r_x3   <= r_x2;
            r_neg3 <= r_neg2;

            r_t4   <= wmg_pkg::SIN_A - w_m3[32:16];
            r_x4   <= r_x3;
            r_neg4 <= r_neg3;

            r_y    <= r_neg4 ? -$signed({1'b0, w_y}) : $signed({1'b0, w_y});
        end
    end

    assign o_val = r_y;

endmodule

// File: rtl/core/windowed_multitone_generator.sv
`timescale 1ns / 1ps
// windowed multitone generator: one windowed, saturated sample per index request
// throughput: one request per cycle while the output is not held, set by the
//   pipelined long dividers (4 bits a stage)
// reset: synchronous active low; clears valid bits and configuration, num_points to 1024
module windowed_multitone_generator #(
    parameter int PHASE_BITS = wmg_pkg::PHASE_BITS_DEF,
    parameter int CHANNELS   = wmg_pkg::CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [wmg_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [wmg_pkg::CFG_W-1:0] i_cfg_data,
    // request stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,  // sample_index[15:0]
    // result stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // sample_value[19:0], zero pad
    output logic [0:0]                m_axis_tuser   // saturated
);

    localparam int STEP = wmg_pkg::DIV_STEP;
    // channel divider: fraction bits cover both phase and sawtooth resolution
    localparam int KC   = (PHASE_BITS > 17) ? PHASE_BITS : 17;
    localparam int TC   = 32 + KC;
    localparam int LC   = (TC + STEP - 1) / STEP;
    // window divider: one extra bit gives the doubled angle for blackman
    localparam int KW   = (PHASE_BITS + 1 > 16) ? PHASE_BITS + 1 : 16;
    localparam int TW   = 17 + KW;
    localparam int LW   = (TW + STEP - 1) / STEP;
    localparam int CH_LAT  = 9 + LC;
    localparam int WIN_LAT = 8 + LW;
    localparam int M    = (CH_LAT > WIN_LAT) ? CH_LAT : WIN_LAT;
    localparam int SIN_LAT = 5;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [wmg_pkg::CFG_W-1:0] r_chan_cfg [CHANNELS];
    logic [2:0]                r_win_mode;
    logic [15:0]               r_num_pts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_chan_cfg[c] <= '0;
            end
            r_win_mode <= wmg_pkg::WIN_NONE;
            r_num_pts  <= wmg_pkg::NPOINTS_RST;
        end else if (i_cfg_we) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (i_cfg_index == wmg_pkg::IDX_W'(c)) begin
                    r_chan_cfg[c] <= i_cfg_data;
                end
            end
            if (i_cfg_index == wmg_pkg::REG_WINDOW) begin
                r_win_mode <= i_cfg_data[2:0];
            end
            if (i_cfg_index == wmg_pkg::REG_NPOINTS) begin
                r_num_pts <= i_cfg_data[15:0];
            end
        end
    end

    // short records are run as two points
    logic [15:0] w_np, w_nm1;
    assign w_np  = (r_num_pts < 16'd2) ? 16'd2 : r_num_pts;
    assign w_nm1 = w_np - 16'd1;

    // ------------------------------------------------------------------
    // pipeline control: whole pipe advances unless the output is held
    // ------------------------------------------------------------------
    logic         w_en;
    logic [M+1:0] r_vld;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[M:0], s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // channel lanes
    // ------------------------------------------------------------------
    logic signed [wmg_pkg::CHV_W-1:0] w_chv [CHANNELS];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
        logic [1:0]  w_kind;
        logic [15:0] w_phase, w_amp, w_freq;
        logic [31:0] r_num;
        logic [TC-1:0] w_quot;
        logic [19:0]   w_rem;
        logic [KC-1:0] w_q;
        logic [PHASE_BITS+15:0] w_pt;
        logic [PHASE_BITS-1:0]  w_ph;
        logic [16:0] w_q17;
        logic [17:0] w_ceil;
        logic [KC-1:0] w_lowmask;
        logic        w_exact, w_zero, w_half;
        logic signed [wmg_pkg::WAVE_W-1:0] n_wv;
        logic [PHASE_BITS-1:0]  r_ang;
        logic signed [wmg_pkg::WAVE_W-1:0] r_wv;
        logic [wmg_pkg::WAVE_W-1:0] w_wv_d;
        logic signed [17:0] w_sin;
        logic signed [wmg_pkg::WAVE_W-1:0] w_sel;
        logic signed [wmg_pkg::CHV_W-1:0]  r_chv;

        assign w_kind  = r_chan_cfg[c][1:0];
        assign w_phase = r_chan_cfg[c][17:2];
        assign w_amp   = r_chan_cfg[c][33:18];
        assign w_freq  = r_chan_cfg[c][49:34];

        // F * n over 16(N-1)
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_num <= w_freq * s_axis_tdata;
            end
        end

        wmg_div #(
            .NUM_W (32),
            .DEN_W (20),
            .FRAC_W(KC),
            .STEP  (STEP)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_num),
            .i_den ({w_nm1, 4'd0}),
            .o_quot(w_quot),
            .o_rem (w_rem)
        );

        // fraction of the record turn, remainder tells exact hits
        assign w_q       = w_quot[KC-1:0];
        assign w_pt      = {w_phase, {PHASE_BITS{1'b0}}};
        assign w_ph      = PHASE_BITS'(w_pt >> 16);
        assign w_q17     = w_q[KC-1 -: 17];
        assign w_lowmask = (KC'(1) << (KC - 17)) - KC'(1);
        assign w_exact   = ((w_q & w_lowmask) == '0) && (w_rem == '0);
        assign w_zero    = (w_q == '0) && (w_rem == '0);
        assign w_half    = (w_q == (KC'(1) << (KC - 1))) && (w_rem == '0);
        assign w_ceil    = {1'b0, w_q17} + {17'd0, !w_exact};

        always_comb begin
            case (w_kind)
                wmg_pkg::WAVE_SQUARE: begin
                    if (w_zero || w_half) begin
                        n_wv = '0;
                    end else if (w_q[KC-1]) begin
                        n_wv = -18'sd65536;
                    end else begin
                        n_wv = 18'sd65536;
                    end
                end
                wmg_pkg::WAVE_SAW: begin
                    // falling half measured from the far end of the cycle
                    if (!w_q[KC-1]) begin
                        n_wv = $signed({1'b0, w_q17});
                    end else begin
                        n_wv = -$signed(18'd131072 - w_ceil);
                    end
                end
                default: begin
                    n_wv = '0;
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ang <= w_q[KC-1 -: PHASE_BITS] + w_ph;
                r_wv  <= n_wv;
            end
        end

        wmg_sine #(
            .PHASE_BITS(PHASE_BITS)
        ) u_sine (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_ang(r_ang),
            .o_val(w_sin)
        );

        wmg_delay #(
            .W    (wmg_pkg::WAVE_W),
            .DEPTH(SIN_LAT)
        ) u_wv_dly (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_data(r_wv),
            .o_data(w_wv_d)
        );

        assign w_sel = (w_kind == wmg_pkg::WAVE_SINE) ? w_sin : $signed(w_wv_d);

        // amplitude q8.8 times wave q16
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_chv <= $signed({1'b0, w_amp}) * w_sel;
            end
        end

        assign w_chv[c] = r_chv;
    end

    // channel sum, floored to q16
    logic signed [wmg_pkg::SUM_W-1:0] w_sum;
    logic signed [wmg_pkg::S16_W-1:0] r_sum16;

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            w_sum = w_sum + wmg_pkg::SUM_W'(w_chv[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum16 <= w_sum[wmg_pkg::SUM_W-1:8];
        end
    end

    // ------------------------------------------------------------------
    // window lane
    // ------------------------------------------------------------------
    logic signed [17:0] w_d;
    logic [17:0]        w_dabs;
    logic signed [18:0] w_m;
    logic [16:0]        w_mabs;
    logic [16:0]        r_wnum;
    logic               r_wneg;
    logic [15:0]        w_wden;

    // bartlett distance from the record centre
    assign w_d    = $signed({1'b0, s_axis_tdata, 1'b0}) - $signed({2'b0, w_nm1});
    assign w_dabs = w_d[17] ? 18'(-w_d) : 18'(w_d);
    assign w_m    = $signed({3'b0, w_nm1}) - $signed({1'b0, w_dabs});
    assign w_mabs = w_m[18] ? 17'(-w_m) : 17'(w_m);

    // hann and hamming run over n/N, the others over n/(N-1)
    assign w_wden = ((r_win_mode == wmg_pkg::WIN_HANN) || (r_win_mode == wmg_pkg::WIN_HAMMING))
                    ? w_np : w_nm1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wnum <= (r_win_mode == wmg_pkg::WIN_BARTLETT) ? w_mabs : {1'b0, s_axis_tdata};
            r_wneg <= w_m[18];
        end
    end

    logic [TW-1:0] w_wquot;
    logic [15:0]   w_wrem;
    logic [0:0]    w_wneg_d;

    wmg_div #(
        .NUM_W (17),
        .DEN_W (16),
        .FRAC_W(KW),
        .STEP  (STEP)
    ) u_wdiv (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_wnum),
        .i_den (w_wden),
        .o_quot(w_wquot),
        .o_rem (w_wrem)
    );

    wmg_delay #(
        .W    (1),
        .DEPTH(LW)
    ) u_neg_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_data(r_wneg),
        .o_data(w_wneg_d)
    );

    logic [PHASE_BITS:0]   w_qa;
    logic [32:0]           w_bmag;
    logic [PHASE_BITS-1:0] r_ca1, r_ca2;
    logic signed [wmg_pkg::WIN_W-1:0] r_bart;
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

    assign w_qa   = w_wquot[KW-1 -: PHASE_BITS+1];
    assign w_bmag = {w_wquot[TW-1:KW], w_wquot[KW-1 -: 16]};

    // cosine is a quarter turn on; the low angle bits give the doubled angle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ca1  <= w_qa[PHASE_BITS:1] + QUARTER;
            r_ca2  <= w_qa[PHASE_BITS-1:0] + QUARTER;
            r_bart <= w_wneg_d[0] ? -$signed({2'b0, w_bmag}) : $signed({2'b0, w_bmag});
        end
    end

    // the divider remainder only matters for the channel lanes
    logic w_wrem_unused;
    assign w_wrem_unused = ^w_wrem;

    logic signed [17:0] w_c1, w_c2;
    logic [wmg_pkg::WIN_W-1:0] w_bart_d;

    wmg_sine #(
        .PHASE_BITS(PHASE_BITS)
    ) u_cos1 (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_ang(r_ca1),
        .o_val(w_c1)
    );

    wmg_sine #(
        .PHASE_BITS(PHASE_BITS)
    ) u_cos2 (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_ang(r_ca2),
        .o_val(w_c2)
    );

    wmg_delay #(
        .W    (wmg_pkg::WIN_W),
        .DEPTH(SIN_LAT)
    ) u_bart_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_data(r_bart),
        .o_data(w_bart_d)
    );

    logic signed [32:0] w_pbk, w_phm;
    logic signed [wmg_pkg::WIN_W-1:0] n_win, r_win;
    logic signed [wmg_pkg::WIN_W-1:0] w_c1x;

    assign w_pbk = wmg_pkg::BK_A2 * w_c2;
    assign w_phm = wmg_pkg::HM_A1 * w_c1;
    assign w_c1x = wmg_pkg::WIN_W'(w_c1);

    always_comb begin
        case (r_win_mode)
            wmg_pkg::WIN_BLACKMAN: begin
                n_win = wmg_pkg::BK_A0 - (w_c1x >>> 1)
                        + wmg_pkg::WIN_W'(w_pbk >>> 16);
            end
            wmg_pkg::WIN_HANN: begin
                n_win = (wmg_pkg::WIN_ONE - w_c1x) >>> 1;
            end
            wmg_pkg::WIN_HAMMING: begin
                n_win = wmg_pkg::HM_A0 - wmg_pkg::WIN_W'(w_phm >>> 16);
            end
            wmg_pkg::WIN_BARTLETT: begin
                n_win = $signed(w_bart_d);
            end
            default: begin
                n_win = wmg_pkg::WIN_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // align the two lanes
    // ------------------------------------------------------------------
    logic signed [wmg_pkg::S16_W-1:0] w_sum_al;
    logic signed [wmg_pkg::WIN_W-1:0] w_win_al;

    if (M > CH_LAT) begin : g_sum_dly
        logic [wmg_pkg::S16_W-1:0] w_tmp;
        wmg_delay #(
            .W    (wmg_pkg::S16_W),
            .DEPTH(M - CH_LAT)
        ) u_dly (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_data(r_sum16),
            .o_data(w_tmp)
        );
        assign w_sum_al = $signed(w_tmp);
    end else begin : g_sum_now
        assign w_sum_al = r_sum16;
    end

    if (M > WIN_LAT) begin : g_win_dly
        logic [wmg_pkg::WIN_W-1:0] w_tmp;
        wmg_delay #(
            .W    (wmg_pkg::WIN_W),
            .DEPTH(M - WIN_LAT)
        ) u_dly (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_data(r_win),
            .o_data(w_tmp)
        );
        assign w_win_al = $signed(w_tmp);
    end else begin : g_win_now
        assign w_win_al = r_win;
    end

    // ------------------------------------------------------------------
    // sum times window in two partial products, then floor and clip
    // ------------------------------------------------------------------
    logic signed [46:0] r_plo, r_phi;
    logic signed [63:0] w_full;
    logic signed [39:0] w_v;
    logic [wmg_pkg::OUT_W-1:0] r_val;
    logic                      r_sat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_plo <= w_sum_al * $signed({1'b0, w_win_al[16:0]});
            r_phi <= w_sum_al * $signed(w_win_al[34:17]);
        end
    end

    assign w_full = (64'(r_phi) <<< 17) + 64'(r_plo);
    assign w_v    = w_full[63:24];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_v > wmg_pkg::OUT_MAX) begin
                r_val <= wmg_pkg::OUT_MAX[wmg_pkg::OUT_W-1:0];
                r_sat <= 1'b1;
            end else if (w_v < wmg_pkg::OUT_MIN) begin
                r_val <= wmg_pkg::OUT_MIN[wmg_pkg::OUT_W-1:0];
                r_sat <= 1'b1;
            end else begin
                r_val <= w_v[wmg_pkg::OUT_W-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_vld[M+1];
    assign m_axis_tdata  = {4'd0, r_val};
    assign m_axis_tuser  = {r_sat ^ (w_wrem_unused & 1'b0)};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_sat_extreme : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ((m_axis_tdata[19:0] == 20'h7FFFF) || (m_axis_tdata[19:0] == 20'h80000)))
        else $error("saturated flag without a clipped value");

    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while the pipe is held");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown straight after reset");

endmodule

// File: sim/windowed_multitone_generator_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the windowed multitone generator
// needs rtl/core/wmg_pkg.sv and rtl/core/windowed_multitone_generator.sv with its submodules
module windowed_multitone_generator_tb;

    localparam int  IDX_W = wmg_pkg::IDX_W;
    localparam int  CFG_W = wmg_pkg::CFG_W;
    localparam int  OUT_W = wmg_pkg::OUT_W;

    localparam int  SETTLE_CYCLES = 40;      // exceeds the pipeline depth, keep some margin
    localparam int  HOLD_CYCLES   = 300;     // long back-pressure stretch
    localparam int  RAND_PHASES   = 10;
    localparam int  PHASE_ITEMS   = 120;
    localparam longint CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // sample_index[15:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [23:0]       m_axis_tdata;   // sample_value[19:0], zero pad
    logic [0:0]        m_axis_tuser;   // saturated

    windowed_multitone_generator i_dut (.*);

    // one expected result of a sample request
    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             sat;
    } t_sample;

    // directed rows: either a register write or a sample request
    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;
    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0] reg_data;
        logic [15:0]      index;
        bit               typed;   // expected value written in the row
        logic [OUT_W-1:0] value;
        logic             sat;
    } t_dir_row;

    t_sample     pending_samples[$];
    int          error_count;
    longint      cycle_count;

    // shadow copy of the configuration
    logic [CFG_W-1:0] shadow_chan[3];
    logic [2:0]       shadow_window;
    logic [15:0]      shadow_npoints;

    // idling controls shared by the stream processes
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    int hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // q16 sine of a 16-bit turn fraction, odd polynomial with quadrant folding
    function automatic longint sine_q16(longint unsigned ang);
        longint unsigned x, x2, t, y;
        logic [1:0] quad;
        ang  = ang & 64'hFFFF;
        quad = ang[15:14];
        x    = ((ang & 64'h3FFF) << 16) >> 14;
        if (quad[0])
            x = 65536 - x;
        x2 = (x * x) >> 16;
        t  = (64'd4640 * x2) >> 16;
        t  = 64'd42047 - t;
        t  = (t * x2) >> 16;
        t  = 64'd102944 - t;
        y  = (t * x) >> 16;
        if (y > 65536)
            y = 65536;
        return quad[1] ? -longint'(y) : longint'(y);
    endfunction

    function automatic longint cosine_q16(longint unsigned ang);
        return sine_q16(ang + 64'h4000);
    endfunction

    function automatic longint unsigned turn_of(longint unsigned num, longint unsigned den);
        return (((num % den) << 16) / den) & 64'hFFFF;
    endfunction

    // one channel in q24
    function automatic longint channel_q24(logic [CFG_W-1:0] cfg, longint unsigned n,
                                           longint unsigned nm1);
        logic [1:0]      kind;
        longint unsigned phase, freq, den, num, r;
        longint          amp, w;
        kind  = cfg[1:0];
        phase = cfg[17:2];
        amp   = longint'(cfg[33:18]);
        freq  = cfg[49:34];
        den   = 16 * nm1;
        num   = freq * n;
        r     = num % den;
        w     = 0;
        case (kind)
            wmg_pkg::WAVE_SINE: w = sine_q16(turn_of(num, den) + phase);
            wmg_pkg::WAVE_SQUARE: begin
                // zero at the exact zero crossings of the sine
                if (r == 0 || 2 * r == den)
                    w = 0;
                else
                    w = (2 * r < den) ? 65536 : -65536;
            end
            wmg_pkg::WAVE_SAW: begin
                if (2 * r < den)
                    w = longint'((2 * r * 65536) / den);
                else
                    w = -longint'((2 * (den - r) * 65536) / den);
            end
            default: w = 0;
        endcase
        return amp * w;
    endfunction

    function automatic longint window_q16(logic [2:0] mode, longint unsigned n,
                                          longint unsigned np);
        longint unsigned nm1, mabs;
        longint c, d, m, mag;
        nm1 = np - 1;
        case (mode)
            wmg_pkg::WIN_BLACKMAN:
                return 27525 - ((32768 * cosine_q16(turn_of(n, nm1))) >>> 16)
                             + ((5243 * cosine_q16(turn_of(2 * n, nm1))) >>> 16);
            wmg_pkg::WIN_HANN: begin
                c = cosine_q16(turn_of(n, np));
                return (65536 - c) / 2;
            end
            wmg_pkg::WIN_HAMMING: begin
                c = cosine_q16(turn_of(n, np));
                return 35389 - ((30147 * c) >>> 16);
            end
            wmg_pkg::WIN_BARTLETT: begin
                // triangle, goes negative past the record
                d = 2 * longint'(n) - longint'(nm1);
                if (d < 0)
                    d = -d;
                m    = longint'(nm1) - d;
                mabs = (m < 0) ? -m : m;
                mag  = longint'((mabs * 65536) / nm1);
                return (m < 0) ? -mag : mag;
            end
            default: return 65536;   // no window, unknown modes too
        endcase
    endfunction

    function automatic t_sample predict_sample(logic [15:0] index);
        longint unsigned n, np;
        longint          total, v;
        t_sample         res;
        n  = index;
        np = (shadow_npoints < 2) ? 2 : shadow_npoints;   // short record clamps to two
        total = 0;
        for (int ch = 0; ch < 3; ch++)
            total += channel_q24(shadow_chan[ch], n, np - 1);
        v = ((total >>> 8) * window_q16(shadow_window, n, np)) >>> 24;
        res.sat = 1'b0;
        if (v > 524287) begin
            v = 524287;
            res.sat = 1'b1;
        end else if (v < -524288) begin
            v = -524288;
            res.sat = 1'b1;
        end
        res.value = v[OUT_W-1:0];
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] chan_word(logic [1:0] kind, logic [15:0] phase,
                                                  logic [15:0] amp, logic [15:0] freq);
        return {freq, amp, phase, kind};
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // waits until the pipeline has drained, then writes one register
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        wait (pending_samples.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            wmg_pkg::REG_CH0, wmg_pkg::REG_CH1, wmg_pkg::REG_CH2: shadow_chan[idx] = data;
            wmg_pkg::REG_WINDOW:  shadow_window  = data[2:0];
            wmg_pkg::REG_NPOINTS: shadow_npoints = data[15:0];
            default: ;   // unknown register, ignored
        endcase
    endtask

    // offers one request and records its expectation once accepted
    task automatic send_request(logic [15:0] index, bit typed, t_sample typed_res);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= index;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready)
                break;
        end
        pending_samples.push_back(typed ? typed_res : predict_sample(index));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request  <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result value=%h sat=%b", $time,
                         m_axis_tdata[OUT_W-1:0], m_axis_tuser[0]);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_axis_tdata[OUT_W-1:0] !== want.value) begin
                    $display("%0t: sample_value expected %h actual %h", $time,
                             want.value, m_axis_tdata[OUT_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             want.sat, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tdata[23:OUT_W] !== '0) begin
                    $display("%0t: pad bits expected 0 actual %h", $time,
                             m_axis_tdata[23:OUT_W]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_dir_row        dir_rows[$];
        t_sample         typed_res;
        logic [15:0]     np, idx;
        logic [CFG_W-1:0] word;
        int              guard;

        error_count    = 0;
        cycle_count    = 0;
        tx_idle_pct    = 38;
        rx_idle_pct    = 51;
        hold_request   = 1'b0;
        hold_left      = 0;
        shadow_chan    = '{default: '0};
        shadow_window  = wmg_pkg::WIN_NONE;
        shadow_npoints = wmg_pkg::NPOINTS_RST;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            // all channels off after reset: silence everywhere
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd0,     1, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd1023,  1, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd1024,  1, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd65535, 1, 20'h0, 1'b0},
            // write to an unknown register changes nothing
            '{ROW_WRITE,  3'd5, {CFG_W{1'b1}}, 16'd0, 0, 20'h0, 1'b0},
            '{ROW_WRITE,  3'd7, {CFG_W{1'b1}}, 16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd1,     1, 20'h0, 1'b0},
            // unit sine a quarter turn ahead: cosine peak of 1.0 at index 0
            '{ROW_WRITE,  wmg_pkg::REG_CH0,
              chan_word(wmg_pkg::WAVE_SINE, 16'h4000, 16'h0100, 16'h0010),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd0,     1, 20'h00100, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd256,   0, 20'h0, 1'b0},
            // full scale square and sawtooth on top
            '{ROW_WRITE,  wmg_pkg::REG_CH1,
              chan_word(wmg_pkg::WAVE_SQUARE, 16'h0, 16'hFFFF, 16'h0010),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_WRITE,  wmg_pkg::REG_CH2,
              chan_word(wmg_pkg::WAVE_SAW, 16'hFFFF, 16'hFFFF, 16'hFFFF),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd0,     0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd511,   0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd1023,  0, 20'h0, 1'b0},
            '{ROW_WRITE,  wmg_pkg::REG_WINDOW, CFG_W'(wmg_pkg::WIN_BLACKMAN),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd300,   0, 20'h0, 1'b0},
            '{ROW_WRITE,  wmg_pkg::REG_WINDOW, CFG_W'(wmg_pkg::WIN_HANN),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd700,   0, 20'h0, 1'b0},
            '{ROW_WRITE,  wmg_pkg::REG_WINDOW, CFG_W'(wmg_pkg::WIN_HAMMING),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd100,   0, 20'h0, 1'b0},
            // triangle window past the end of the record turns negative
            '{ROW_WRITE,  wmg_pkg::REG_WINDOW, CFG_W'(wmg_pkg::WIN_BARTLETT),
              16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd600,   0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd5000,  0, 20'h0, 1'b0},
            // record length below two behaves as two, drives the output into clipping
            '{ROW_WRITE,  wmg_pkg::REG_NPOINTS, CFG_W'(0), 16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd65535, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd40000, 0, 20'h0, 1'b0},
            '{ROW_WRITE,  wmg_pkg::REG_NPOINTS, CFG_W'(1), 16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd3,     0, 20'h0, 1'b0},
            // unknown window mode acts as no window, longest record
            '{ROW_WRITE,  wmg_pkg::REG_WINDOW, CFG_W'(7), 16'd0, 0, 20'h0, 1'b0},
            '{ROW_WRITE,  wmg_pkg::REG_NPOINTS, CFG_W'(16'hFFFF), 16'd0, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd65535, 0, 20'h0, 1'b0},
            '{ROW_SAMPLE, wmg_pkg::REG_CH0, '0, 16'd32767, 0, 20'h0, 1'b0}
        };

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
            end else begin
                typed_res.value = dir_rows[r].value;
                typed_res.sat   = dir_rows[r].sat;
                send_request(dir_rows[r].index, dir_rows[r].typed, typed_res);
                end_burst();
            end
        end

        // random phases, each with a fresh configuration
        for (int p = 0; p < RAND_PHASES; p++) begin
            end_burst();
            // idling schedule: receiver-heavy, then sender-heavy, then none
            if (p < 3) begin
                tx_idle_pct = 38;
                rx_idle_pct = 51;
            end else if (p < 7) begin
                tx_idle_pct = 51;
                rx_idle_pct = 38;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int ch = 0; ch < 3; ch++) begin
                word = CFG_W'({$urandom, $urandom});
                // mostly moderate amplitudes so clipping stays the exception
                if ($urandom_range(3) != 0)
                    word[33:18] = 16'($urandom_range(16'h0200));
                if ($urandom_range(1) == 0)
                    word[49:34] = 16'($urandom_range(16'h0400));
                write_reg(ch[IDX_W-1:0], word);
            end
            write_reg(wmg_pkg::REG_WINDOW, CFG_W'($urandom_range(7)));
            case (p % 4)
                0:       np = 16'd2;
                1:       np = 16'hFFFF;
                2:       np = 16'($urandom_range(2, 64));
                default: np = 16'($urandom);
            endcase
            write_reg(wmg_pkg::REG_NPOINTS, CFG_W'(np));
            if ($urandom_range(2) == 0)
                write_reg(IDX_W'($urandom_range(5, 7)), CFG_W'({$urandom, $urandom}));
            if (p == 7)
                hold_request = 1'b1;   // long stall while the sender keeps pushing
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly inside the record, sometimes anywhere
                if ($urandom_range(4) == 0 || np < 2)
                    idx = 16'($urandom);
                else
                    idx = 16'($urandom_range(np));
                typed_res = '0;
                send_request(idx, 0, typed_res);
            end
        end
        end_burst();

        // drain, then let the pipeline settle
        guard = 0;
        while (pending_samples.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_samples.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_samples.size());
            error_count++;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/wmg_pkg.sv
rtl/core/wmg_delay.sv
rtl/core/wmg_div.sv
rtl/core/wmg_sine.sv
rtl/core/windowed_multitone_generator.sv
sim/windowed_multitone_generator_tb.sv
